/* hdl/mptest_pkg.sv */
// Shared types, constants and pattern function of the memory pattern test engine.
package mptest_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_WIDTH_DEF = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PHASE_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 2'd1;

  // Pattern phases, run in this order
  localparam logic [PHASE_W-1:0] PH_ALT_HI  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ALT_LO  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ONES    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ZEROS   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ADDR    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd5;

  localparam logic [DATA_W-1:0] PAT_ALT_HI = 32'hAAAA_AAAA;
  localparam logic [DATA_W-1:0] PAT_ALT_LO = 32'h5555_5555;
  localparam logic [DATA_W-1:0] PAT_ONES   = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] PAT_ZEROS  = 32'h0000_0000;

  typedef struct packed {
    logic              launch;
    logic [DATA_W-1:0] read_word;
  } in_t;

  typedef struct packed {
    logic              req_valid;
    logic              req_write;
    logic [DATA_W-1:0] req_address;
    logic [DATA_W-1:0] write_word;
    logic              busy_res;
    logic              finished;
    logic              passed;
    logic [DATA_W-1:0] fail_address;
  } out_t;

  function automatic logic [DATA_W-1:0] pattern_for(input logic [PHASE_W-1:0] phase,
                                                    input logic [DATA_W-1:0]  addr);
    logic [DATA_W-1:0] pat;
    case (phase)
      PH_ALT_HI: pat = PAT_ALT_HI;
      PH_ALT_LO: pat = PAT_ALT_LO;
      PH_ONES:   pat = PAT_ONES;
      PH_ZEROS:  pat = PAT_ZEROS;
      default:   pat = addr;
    endcase
    return pat;
  endfunction

endpackage

/* hdl/memory_pattern_test_engine_core.sv */
// Top level of the memory pattern test engine: tick register, sequencer and result register.
//
// Word-wide memory self-test sequencer. A launch tick while idle latches the
// configured region (start rounded up, end rounded down to a word boundary)
// and then writes and reads back five patterns in turn: 0xAAAAAAAA,
// 0x55555555, all ones, all zeros and each word's own byte address. Every
// accepted tick yields exactly one result, which carries at most one memory
// request; read data for a read request comes back on the next tick's
// read_word. The run ends on the first mismatch (reporting that word's
// address) or one tick after the last read of the address pattern; an empty
// region finishes with a pass on the launch tick itself. Throughput is one
// tick per clock unless out_ready stalls: a tick is held in the input
// register, the sequencer computes its result combinationally (one 32-bit
// address add and one data compare) and writes the result register.
// Configuration writes are always taken and only act at the next launch.
module memory_pattern_test_engine_core #(
  parameter int unsigned ADDR_WIDTH = mptest_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mptest_pkg::in_t                     in_payload,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mptest_pkg::out_t                    out_payload,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mptest_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mptest_pkg::DATA_W-1:0]       cfg_data
);
  import mptest_pkg::*;

  localparam int unsigned AW = ADDR_WIDTH;
  localparam int unsigned IW = ADDR_WIDTH - 2;

  // Configuration registers, kept at address width
  logic [AW-1:0] region_start_r;
  logic [AW-1:0] region_end_r;

  // Input request register
  logic in_valid_r;
  in_t  in_data_r;

  // Sequencer state
  logic               running_r, running_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               write_pass_r, write_pass_nxt;
  logic [IW-1:0]      word_index_r, word_index_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic [IW-1:0]      word_count_r, word_count_nxt;
  logic               chk_pend_r, chk_pend_nxt;
  logic [AW-1:0]      chk_addr_r, chk_addr_nxt;
  logic [DATA_W-1:0]  chk_exp_r, chk_exp_nxt;

  // Result register
  logic out_valid_r;
  out_t out_r, out_nxt;

  logic advance;

  // The result register frees up when empty or when its request is taken
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

  always_comb begin
    logic               fail;
    logic               fin;
    logic [AW:0]        start_al;
    logic [AW-1:0]      end_al;
    logic [AW-1:0]      span;
    logic [AW-1:0]      addr;
    logic [DATA_W-1:0]  addr_w;
    logic [DATA_W-1:0]  pat;
    logic [IW-1:0]      idx_inc;

    running_nxt    = running_r;
    phase_nxt      = phase_r;
    write_pass_nxt = write_pass_r;
    word_index_nxt = word_index_r;
    base_nxt       = base_r;
    word_count_nxt = word_count_r;
    chk_pend_nxt   = 1'b0;
    chk_addr_nxt   = chk_addr_r;
    chk_exp_nxt    = chk_exp_r;
    out_nxt        = '0;

    // Check the read data answering the previous read request
    fail = chk_pend_r && (in_data_r.read_word != chk_exp_r);
    fin  = fail;
    if (fail) begin
      running_nxt          = 1'b0;
      out_nxt.fail_address = DATA_W'(chk_addr_r);
    end

    // Align the region: start up (no wrap), end down to a word
    start_al = ({1'b0, region_start_r} + (AW+1)'(3)) & ~(AW+1)'(3);
    end_al   = region_end_r & ~AW'(3);
    span     = end_al - start_al[AW-1:0];

    if (!running_r && !fail && in_data_r.launch) begin
      if (start_al >= {1'b0, end_al}) begin
        fin            = 1'b1;
        out_nxt.passed = 1'b1;
      end else begin
        running_nxt    = 1'b1;
        phase_nxt      = PH_ALT_HI;
        write_pass_nxt = 1'b1;
        word_index_nxt = '0;
        base_nxt       = start_al[AW-1:0];
        word_count_nxt = span[AW-1:2];
      end
    end else if (running_r && !fail && phase_r > PH_ADDR) begin
      running_nxt    = 1'b0;
      fin            = 1'b1;
      out_nxt.passed = 1'b1;
    end

    // Issue one request from the (possibly just launched) state
    addr    = base_nxt + {word_index_nxt, 2'b00};
    addr_w  = DATA_W'(addr);
    pat     = pattern_for(phase_nxt, addr_w);
    idx_inc = word_index_nxt + IW'(1);
    if (running_nxt && !fin && phase_nxt <= PH_ADDR) begin
      out_nxt.req_valid   = 1'b1;
      out_nxt.req_address = addr_w;
      if (write_pass_nxt) begin
        out_nxt.req_write  = 1'b1;
        out_nxt.write_word = pat;
      end else begin
        chk_pend_nxt = 1'b1;
        chk_addr_nxt = addr;
        chk_exp_nxt  = pat;
      end
      if (idx_inc >= word_count_nxt) begin
        word_index_nxt = '0;
        if (write_pass_nxt) begin
          write_pass_nxt = 1'b0;
        end else begin
          write_pass_nxt = 1'b1;
          phase_nxt      = phase_nxt + PHASE_W'(1);
        end
      end else begin
        word_index_nxt = idx_inc;
      end
    end

    out_nxt.busy_res = running_nxt;
    out_nxt.finished = fin;
  end

  // Configuration writes; out-of-range indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_end_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REGION_START: region_start_r <= cfg_data[AW-1:0];
        REG_REGION_END:   region_end_r   <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // Input request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_payload;
    end
  end

  // Advance the sequencer and fill the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      running_r    <= 1'b0;
      phase_r      <= PH_ALT_HI;
      write_pass_r <= 1'b1;
      word_index_r <= '0;
      base_r       <= '0;
      word_count_r <= '0;
      chk_pend_r   <= 1'b0;
      chk_addr_r   <= '0;
      chk_exp_r    <= '0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        running_r    <= running_nxt;
        phase_r      <= phase_nxt;
        write_pass_r <= write_pass_nxt;
        word_index_r <= word_index_nxt;
        base_r       <= base_nxt;
        word_count_r <= word_count_nxt;
        chk_pend_r   <= chk_pend_nxt;
        chk_addr_r   <= chk_addr_nxt;
        chk_exp_r    <= chk_exp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTH
  // A pending read check only exists inside a run
  a_chk_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    chk_pend_r |-> running_r)
    else $error("read check pending while idle");

  // The phase never runs past the end marker
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (phase_r <= PH_DONE))
    else $error("pattern phase out of range");

  // A finishing result never carries a memory request
  a_fin_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.finished) |-> (!out_r.req_valid && !out_r.busy_res))
    else $error("request issued on finishing step");

  // A request is only issued while the run continues
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.req_valid) |-> out_r.busy_res)
    else $error("request issued outside a run");
`endif

endmodule

/* tb/sv/mptest_sequence_checker.sv */
// Checker for the memory pattern test engine: predicts every result and compares it.
`timescale 1ns / 1ps

module mptest_sequence_checker
  import mptest_pkg::*;
#(
  parameter int unsigned ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_t                  in_payload,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_t                 out_payload,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   backlog,
  output int                   mismatches
);

  localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - ADDR_WIDTH);
  localparam int          PRINT_CAP = 40;

  // Copy of the region registers, taken from the configuration channel
  logic [31:0]        start_copy;
  logic [31:0]        end_copy;

  // Sequencer state as the engine should hold it
  logic               run_on;
  logic [PHASE_W-1:0] phase;
  logic               write_sweep;
  logic [29:0]        word_idx;
  logic [31:0]        base_addr;
  logic [30:0]        n_words;
  logic               read_owed;
  logic [31:0]        owed_addr;
  logic [31:0]        owed_word;

  out_t               expected_results[$];
  out_t               want;
  int                 result_no;

  initial begin
    backlog    = 0;
    mismatches = 0;
    result_no  = 0;
  end

  // Advance the sequencer by one request and return the result it owes.
  function automatic out_t step_engine(input in_t req);
    out_t        r;
    logic [32:0] lo;
    logic [32:0] hi;
    logic [31:0] addr;
    logic [31:0] pat;
    r = '0;
    if (read_owed) begin
      read_owed = 1'b0;
      if (req.read_word != owed_word) begin
        run_on         = 1'b0;
        r.finished     = 1'b1;
        r.fail_address = owed_addr;
      end
    end
    if (!run_on && !r.finished && req.launch) begin
      lo = ({1'b0, start_copy & ADDR_MASK} + 33'd3) & ~33'd3;
      hi = {1'b0, end_copy & ADDR_MASK} & ~33'd3;
      if (lo >= hi) begin
        r.finished = 1'b1;
        r.passed   = 1'b1;
      end else begin
        run_on      = 1'b1;
        phase       = PH_ALT_HI;
        write_sweep = 1'b1;
        word_idx    = '0;
        base_addr   = lo[31:0];
        n_words     = 31'((hi - lo) >> 2);
      end
    end else if (run_on && !r.finished && phase > PH_ADDR) begin
      run_on     = 1'b0;
      r.finished = 1'b1;
      r.passed   = 1'b1;
    end
    if (run_on && !r.finished && phase <= PH_ADDR) begin
      addr = base_addr + {word_idx, 2'b00};
      if (phase == PH_ALT_HI)      pat = PAT_ALT_HI;
      else if (phase == PH_ALT_LO) pat = PAT_ALT_LO;
      else if (phase == PH_ONES)   pat = PAT_ONES;
      else if (phase == PH_ZEROS)  pat = PAT_ZEROS;
      else                         pat = addr;
      r.req_valid   = 1'b1;
      r.req_address = addr;
      if (write_sweep) begin
        r.req_write  = 1'b1;
        r.write_word = pat;
      end else begin
        read_owed = 1'b1;
        owed_addr = addr;
        owed_word = pat;
      end
      word_idx = word_idx + 30'd1;
      if ({1'b0, word_idx} >= n_words) begin
        word_idx = '0;
        if (write_sweep) begin
          write_sweep = 1'b0;
        end else begin
          write_sweep = 1'b1;
          phase       = phase + 3'd1;
        end
      end
    end
    r.busy_res = run_on;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] predicted);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] result %0d: %s is %h, predicted %h",
               $time, result_no, what, got, predicted);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_copy  = '0;
      end_copy    = '0;
      run_on      = 1'b0;
      phase       = PH_ALT_HI;
      write_sweep = 1'b1;
      word_idx    = '0;
      base_addr   = '0;
      n_words     = '0;
      read_owed   = 1'b0;
      owed_addr   = '0;
      owed_word   = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REGION_START: start_copy = cfg_data;
          REG_REGION_END:   end_copy   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(step_engine(in_payload));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result, req_address", out_payload.req_address, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_payload.req_valid !== want.req_valid)
            note_mismatch("req_valid", out_payload.req_valid, want.req_valid);
          if (out_payload.req_write !== want.req_write)
            note_mismatch("req_write", out_payload.req_write, want.req_write);
          if (out_payload.req_address !== want.req_address)
            note_mismatch("req_address", out_payload.req_address, want.req_address);
          if (out_payload.write_word !== want.write_word)
            note_mismatch("write_word", out_payload.write_word, want.write_word);
          if (out_payload.busy_res !== want.busy_res)
            note_mismatch("busy_res", out_payload.busy_res, want.busy_res);
          if (out_payload.finished !== want.finished)
            note_mismatch("finished", out_payload.finished, want.finished);
          if (out_payload.passed !== want.passed)
            note_mismatch("passed", out_payload.passed, want.passed);
          if (out_payload.fail_address !== want.fail_address)
            note_mismatch("fail_address", out_payload.fail_address, want.fail_address);
        end
        result_no++;
      end
    end
    backlog <= expected_results.size();
  end

endmodule

/* tb/sv/tb_memory_pattern_test_engine_core.sv */
// Testbench top for the memory pattern test engine: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_memory_pattern_test_engine_core;
  import mptest_pkg::*;

  localparam int unsigned ITEM_GOAL  = 1650;
  localparam int unsigned TIMEOUT_NS = 6_000_000;
  localparam int unsigned DRAIN_WAIT = 4;

  // Indexes past the two region registers; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  in_t                  in_payload = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  out_t                 out_payload;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [DATA_W-1:0]    cfg_data   = '0;

  int                   backlog;
  int                   mismatch_total;

  // Pacing knobs, in percent: sender gaps and receiver stalls
  int unsigned          gap_pct    = 0;
  int unsigned          stall_pct  = 0;

  // Region as last written to the block, and requests sent inside test runs
  logic [31:0]          cur_start  = '0;
  logic [31:0]          cur_end    = '0;
  int unsigned          run_reqs   = 0;

  memory_pattern_test_engine_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  mptest_sequence_checker seq_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .backlog     (backlog),
    .mismatches  (mismatch_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: stall at random according to stall_pct; zero means always ready.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hand one request to the block. Hold valid and payload until accepted;
  // drop valid only for a gap, so valid is never lowered and raised in one step.
  task automatic send_request(input logic launch, input logic [31:0] word);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= '{launch: launch, read_word: word};
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every predicted result is out, then the
  // DRAIN_WAIT margin, so that the block is truly idle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write one register; the caller drops cfg_valid after the last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Program a new region while idle; sometimes poke an unused index as well.
  task automatic set_region(input logic [31:0] start_addr, input logic [31:0] stop_addr);
    wait_quiet();
    if ($urandom_range(0, 2) == 0) begin
      cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    end
    if ($urandom_range(0, 1)) begin
      cfg_write(REG_REGION_START, start_addr);
      cfg_write(REG_REGION_END, stop_addr);
    end else begin
      cfg_write(REG_REGION_END, stop_addr);
      cfg_write(REG_REGION_START, start_addr);
    end
    cfg_valid <= 1'b0;
    cur_start = start_addr;
    cur_end   = stop_addr;
  endtask

  // Drive one full test run over the current region. The engine's access
  // order is fixed: per pattern n writes then n reads, so the read data to
  // return with each request is known in advance. With corrupt set, flip
  // bits in the answer to one read and stop there, since the run ends.
  task automatic run_test(input bit corrupt);
    logic [32:0] lo;
    logic [32:0] hi;
    logic [31:0] word;
    logic [31:0] addr;
    logic        launch;
    int unsigned n;
    int unsigned last;
    int unsigned bad_req;
    int unsigned j;
    int unsigned p;
    int unsigned w;
    lo = ({1'b0, cur_start} + 33'd3) & ~33'd3;
    hi = {1'b0, cur_end} & ~33'd3;
    if (lo >= hi) begin
      // empty region: the launch alone passes
      send_request(1'b1, $urandom);
      run_reqs++;
      return;
    end
    n       = int'((hi - lo) >> 2);
    last    = 10 * n;
    bad_req = last + 1;
    if (corrupt) begin
      bad_req = $urandom_range(0, 4) * 2 * n + n + $urandom_range(0, n - 1) + 1;
    end
    for (int k = 0; k <= last; k++) begin
      word = $urandom;
      if (k > 0) begin
        j = k - 1;
        p = j / (2 * n);
        w = j % (2 * n);
        if (w >= n) begin
          // previous request was a read: answer with what was written
          addr = lo[31:0] + 32'(4 * (w - n));
          word = pattern_for(3'(p), addr);
          if (k == bad_req) begin
            if ($urandom_range(0, 1)) word ^= 32'd1 << $urandom_range(0, 31);
            else                      word ^= $urandom | 32'd1;
          end
        end
      end
      // a stray launch in mid-run must be ignored
      launch = (k == 0) || ($urandom_range(0, 7) == 0);
      send_request(launch, word);
      run_reqs++;
      if (k == bad_req) break;
    end
  endtask

  // Draw a region: mostly a few words at a random spot, now and then a
  // longer one, one at the top of the address space, near zero, or empty.
  task automatic pick_region();
    logic [31:0] s;
    logic [31:0] e;
    int unsigned words;
    words = ($urandom_range(0, 19) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
    s     = $urandom_range(0, 32'hFFFF_FE00);
    case ($urandom_range(0, 9))
      0: e = s + $urandom_range(0, 3);
      1: e = $urandom_range(0, s);
      2: begin
        e = 32'hFFFF_FFFF;
        s = e - 32'(4 * words) - $urandom_range(0, 3);
      end
      3: begin
        s = $urandom_range(0, 3);
        e = ((s + 32'd3) & ~32'd3) + 32'(4 * words) + $urandom_range(0, 3);
      end
      default: e = ((s + 32'd3) & ~32'd3) + 32'(4 * words) + $urandom_range(0, 3);
    endcase
    set_region(s, e);
  endtask

  initial begin
    int unsigned goal;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle request, launch on reset registers (empty region),
    // start rounding at the top that must not wrap (empty), a one-word
    // pass with address extremes, and a one-word mismatch near the top.
    send_request(1'b0, 32'hFFFF_FFFF);
    run_test(1'b0);
    set_region(32'hFFFF_FFFD, 32'hFFFF_FFFF);
    run_test(1'b0);
    set_region(32'h0000_0001, 32'h0000_0008);
    run_test(1'b0);
    set_region(32'hFFFF_FFF8, 32'hFFFF_FFFF);
    run_test(1'b1);

    // Random runs under four pacing modes: none, sender gaps, receiver
    // stalls, then light pressure on both sides.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 75; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 75; end
        default: begin gap_pct = 14; stall_pct = 14; end
      endcase
      goal = ITEM_GOAL * (mode + 1) / 4;
      while (run_reqs < goal) begin
        // reuse the region now and then, so a launch follows the end back to back
        if ($urandom_range(0, 3) != 0) pick_region();
        repeat ($urandom_range(0, 2)) send_request(1'b0, $urandom);
        run_test($urandom_range(0, 3) == 0);
      end
    end

    wait_quiet();
    if (mismatch_total == 0) begin
      $display("memory_pattern_test_engine_core: match");
    end else begin
      $display("memory_pattern_test_engine_core: mismatch");
    end
    $finish;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #(TIMEOUT_NS);
    $display("memory_pattern_test_engine_core: mismatch");
    $finish;
  end

endmodule

/* files.f */
hdl/mptest_pkg.sv
hdl/memory_pattern_test_engine_core.sv
tb/sv/mptest_sequence_checker.sv
tb/sv/tb_memory_pattern_test_engine_core.sv
